[rtl/kpws_pkg.sv]
// Package for the keypad predictive word search block.
// Holds sizes, payload and command types, state encoding and the keypad letter check.
// No dependencies.
package kpws_pkg;

  // Sizes
  localparam int MAX_KEYS    = 10;
  localparam int DICT_WORDS  = 2048;
  localparam int WORD_LEN    = 16;
  localparam int MAX_OUT     = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam int FUNC_W = 3;
  localparam int KEY_W  = 4;
  localparam int ROOM_W = 5;
  localparam int SLOT_W = 11;
  localparam int POS_W  = 4;
  localparam int CHAR_W = 8;
  localparam int CNT_W  = 5;
  localparam int CFG_W  = 12;

  localparam int IDX_W  = $clog2(DICT_WORDS);
  localparam int SCAN_W = $clog2(DICT_WORDS + 1);
  localparam int LEN_W  = $clog2(WORD_LEN);
  localparam int KCNT_W = $clog2(MAX_KEYS + 1);
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Function codes on the command channel
  localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_REWIND = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_NEXT   = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_HAS    = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 3'd6;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_CLEAR,
    OP_REWIND,
    OP_NEXT,
    OP_HAS,
    OP_LOAD,
    OP_BAD
  } kpws_op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_EMIT
  } kpws_state_t;

  // Input transaction
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [ROOM_W-1:0] max_chars;
    logic [SLOT_W-1:0] word_slot;
    logic [POS_W-1:0]  char_pos;
    logic [CHAR_W-1:0] char_value;
  } kpws_in_t;

  // Result transaction
  typedef struct packed {
    logic              status;
    logic              found;
    logic [IDX_W-1:0]  word_index;
    logic [CHAR_W-1:0] character;
    logic              char_valid;
    logic [CNT_W-1:0]  char_count;
    logic              last;
  } kpws_out_t;

  // Classified command between front and back
  typedef struct packed {
    kpws_op_t          op;
    logic [KEY_W-1:0]  key;
    logic [ROOM_W-1:0] room_m1;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] value;
    logic              load_ok;
  } kpws_cmd_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } kpws_qstat_t;

  // True when a character belongs to the letter set of a key (digit included)
  function automatic logic in_set(input logic [CHAR_W-1:0] ch, input logic [KEY_W-1:0] k);
    logic r;
    case (k)
      4'd0: r = (ch == "0");
      4'd1: r = (ch == "1");
      4'd2: r = (ch == "2") || (ch == "a") || (ch == "b") || (ch == "c");
      4'd3: r = (ch == "3") || (ch == "d") || (ch == "e") || (ch == "f");
      4'd4: r = (ch == "4") || (ch == "g") || (ch == "h") || (ch == "i");
      4'd5: r = (ch == "5") || (ch == "j") || (ch == "k") || (ch == "l");
      4'd6: r = (ch == "6") || (ch == "m") || (ch == "n") || (ch == "o");
      4'd7: r = (ch == "7") || (ch == "p") || (ch == "q") || (ch == "r") || (ch == "s");
      4'd8: r = (ch == "8") || (ch == "t") || (ch == "u") || (ch == "v");
      4'd9: r = (ch == "9") || (ch == "w") || (ch == "x") || (ch == "y") || (ch == "z");
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[rtl/kpws_front.sv]
// Front end: accepts input transactions, classifies them into commands.
// Depends on kpws_pkg; feeds kpws_queue.
module kpws_front
  import kpws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  kpws_in_t    cmd,
  input  kpws_qstat_t qstat,
  output logic        push,
  output kpws_cmd_t   push_cmd
);

  logic      held;
  kpws_cmd_t held_cmd;
  kpws_cmd_t cls;

  // Classify the incoming transaction
  always_comb begin
    cls.key     = cmd.key;
    cls.slot    = cmd.word_slot;
    cls.pos     = cmd.char_pos;
    cls.value   = cmd.char_value;
    cls.load_ok = (32'(cmd.word_slot) < DICT_WORDS) && (32'(cmd.char_pos) < WORD_LEN);
    if (cmd.max_chars == '0) begin
      cls.room_m1 = '0;
    end else begin
      cls.room_m1 = cmd.max_chars - ROOM_W'(1);
    end
    case (cmd.func)
      FUNC_PUSH:   cls.op = OP_PUSH;
      FUNC_POP:    cls.op = OP_POP;
      FUNC_CLEAR:  cls.op = OP_CLEAR;
      FUNC_REWIND: cls.op = OP_REWIND;
      FUNC_NEXT:   cls.op = OP_NEXT;
      FUNC_HAS:    cls.op = OP_HAS;
      FUNC_LOAD:   cls.op = OP_LOAD;
      default:     cls.op = OP_BAD;
    endcase
  end

  // Hold one command until the queue takes it
  assign push      = held && !qstat.full;
  assign cmd_stall = held && qstat.full;
  assign push_cmd  = held_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (cmd_valid && !cmd_stall) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      held_cmd <= cls;
    end
  end

endmodule

[rtl/kpws_queue.sv]
// Short command queue between the front end and the search engine.
// Depends on kpws_pkg.
module kpws_queue
  import kpws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  kpws_cmd_t   push_cmd,
  input  logic        pop,
  output kpws_cmd_t   head,
  output kpws_qstat_t qstat
);

  kpws_cmd_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;

  assign qstat.full  = (32'(fill) == QUEUE_DEPTH);
  assign qstat.empty = (fill == '0);
  assign head        = slots[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

[rtl/kpws_back.sv]
// Search engine: key stack, scan position, dictionary memory and result register.
// Depends on kpws_pkg; takes commands from kpws_queue.
module kpws_back
  import kpws_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [CFG_W-1:0] cfg_data,
  input  kpws_cmd_t        head,
  input  kpws_qstat_t      qstat,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_stall,
  output kpws_out_t        res
);

  typedef logic [WORD_LEN-1:0][CHAR_W-1:0] row_t;

  // Dictionary, one row per entry
  row_t dict_mem [DICT_WORDS];

  logic [KEY_W-1:0]  key_stack [MAX_KEYS];
  logic [KCNT_W-1:0] key_count;
  logic [SCAN_W-1:0] scan_start;
  logic [CFG_W-1:0]  dict_words;
  logic [SCAN_W-1:0] limit;

  kpws_state_t state, state_next;
  kpws_cmd_t   cur;

  logic [SCAN_W-1:0] rd_addr;
  logic              rd_valid;
  logic [IDX_W-1:0]  rd_idx;
  row_t              rd_row;

  logic              hit_found;
  logic [IDX_W-1:0]  hit_idx;
  row_t              hit_row;
  logic [CNT_W-1:0]  cnt;
  logic [POS_W-1:0]  emit_pos;

  logic out_free;
  logic exec_simple, start_scan, issue, hit, miss, emit, emit_last;
  logic row_match;
  logic [LEN_W-1:0] row_len;
  logic [CNT_W-1:0] row_cnt;
  logic simple_fail;
  kpws_out_t res_next;

  assign out_free = !res_valid || !res_stall;
  assign limit    = (32'(dict_words) > DICT_WORDS) ? SCAN_W'(DICT_WORDS) : SCAN_W'(dict_words);

  // Compare the fetched row against every key position at once
  always_comb begin
    row_match = 1'b1;
    for (int i = 0; i < MAX_KEYS; i++) begin
      if ((KCNT_W'(i) < key_count) && !in_set(rd_row[i], key_stack[i])) begin
        row_match = 1'b0;
      end
    end
  end

  // Length of the fetched row: first zero byte, else truncated
  always_comb begin
    row_len = LEN_W'(WORD_LEN - 1);
    for (int p = WORD_LEN - 2; p >= 0; p--) begin
      if (rd_row[p] == '0) begin
        row_len = LEN_W'(p);
      end
    end
    if (CNT_W'(row_len) < cur.room_m1) begin
      row_cnt = CNT_W'(row_len);
    end else begin
      row_cnt = cur.room_m1;
    end
    if (32'(row_cnt) > MAX_OUT) begin
      row_cnt = CNT_W'(MAX_OUT);
    end
  end

  // Fail flag for single-result commands
  always_comb begin
    case (head.op)
      OP_PUSH:   simple_fail = (32'(key_count) >= MAX_KEYS);
      OP_POP:    simple_fail = (key_count == '0);
      OP_LOAD:   simple_fail = !head.load_ok;
      OP_CLEAR:  simple_fail = 1'b0;
      OP_REWIND: simple_fail = 1'b0;
      default:   simple_fail = 1'b1;
    endcase
  end

  assign emit_last = !hit_found || (cur.op == OP_HAS) || (cnt == '0) ||
                     (CNT_W'(emit_pos) + CNT_W'(1) == cnt);

  // Sequencer outputs
  always_comb begin
    pop         = 1'b0;
    exec_simple = 1'b0;
    start_scan  = 1'b0;
    issue       = 1'b0;
    hit         = 1'b0;
    miss        = 1'b0;
    emit        = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!qstat.empty && out_free) begin
          pop = 1'b1;
          if (head.op == OP_NEXT || head.op == OP_HAS) begin
            start_scan = 1'b1;
          end else begin
            exec_simple = 1'b1;
          end
        end
      end
      BK_SCAN: begin
        hit   = rd_valid && row_match;
        issue = !hit && (rd_addr < limit);
        miss  = !hit && !rd_valid && (rd_addr >= limit);
      end
      BK_EMIT: begin
        emit = out_free;
      end
      default: begin
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (start_scan) state_next = BK_SCAN;
      BK_SCAN: if (hit || miss) state_next = BK_EMIT;
      BK_EMIT: if (emit && emit_last) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      key_count  <= '0;
      scan_start <= '0;
      dict_words <= '0;
      rd_valid   <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (cfg_write) begin
        dict_words <= cfg_data;
      end
      if (exec_simple) begin
        case (head.op)
          OP_PUSH:   if (!simple_fail) key_count <= key_count + KCNT_W'(1);
          OP_POP:    if (!simple_fail) key_count <= key_count - KCNT_W'(1);
          OP_CLEAR: begin
            key_count  <= '0;
            scan_start <= '0;
          end
          OP_REWIND: scan_start <= '0;
          default: begin
          end
        endcase
      end
      if (hit && cur.op == OP_NEXT) begin
        scan_start <= SCAN_W'(rd_idx) + SCAN_W'(1);
      end
      if (miss && cur.op == OP_NEXT) begin
        scan_start <= '0;
      end
      if (exec_simple || emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Key stack write
  always_ff @(posedge clk) begin
    if (exec_simple && head.op == OP_PUSH && !simple_fail) begin
      key_stack[key_count[$clog2(MAX_KEYS)-1:0]] <= head.key;
    end
  end

  // Dictionary: byte write on load, row read for the scan
  always_ff @(posedge clk) begin
    if (exec_simple && head.op == OP_LOAD && head.load_ok) begin
      dict_mem[head.slot[IDX_W-1:0]][head.pos[LEN_W-1:0]] <= head.value;
    end
    rd_row <= dict_mem[rd_addr[IDX_W-1:0]];
  end

  // Scan address, hit capture and emit position
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (start_scan) begin
      rd_addr <= scan_start;
    end else if (issue) begin
      rd_addr <= rd_addr + SCAN_W'(1);
    end
    rd_idx <= rd_addr[IDX_W-1:0];
    if (hit) begin
      hit_found <= 1'b1;
      hit_idx   <= rd_idx;
      hit_row   <= rd_row;
      cnt       <= row_cnt;
      emit_pos  <= '0;
    end else if (miss) begin
      hit_found <= 1'b0;
    end else if (emit) begin
      emit_pos <= emit_pos + POS_W'(1);
    end
  end

  // Build the next result transaction
  always_comb begin
    res_next = res;
    if (exec_simple) begin
      res_next        = '0;
      res_next.status = simple_fail;
      res_next.last   = 1'b1;
    end else if (emit) begin
      res_next      = '0;
      res_next.last = emit_last;
      if (!hit_found) begin
        res_next.status = 1'b1;
      end else begin
        res_next.found      = 1'b1;
        res_next.word_index = hit_idx;
        if (cur.op == OP_NEXT && cnt != '0) begin
          res_next.character  = hit_row[emit_pos];
          res_next.char_valid = 1'b1;
          res_next.char_count = cnt;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

[rtl/keypad_predictive_word_search.sv]
// Keypad predictive word search, top level.
// Simple commands pass through the front-end holding register and the queue to the result register.
// Get next / has next scan from the scan position until an entry matches or the entry limit is reached;
// get next then sends one character per cycle while the result is not stalled.
// Simple commands one per cycle when not stalled; a search holds the engine until its last result.
// Reset (rst, synchronous) empties the key stack, rewinds the scan and zeroes the entry count.
module keypad_predictive_word_search
  import kpws_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  kpws_in_t         cmd,
  output logic             res_valid,
  input  logic             res_stall,
  output kpws_out_t        res
);

  logic        push;
  kpws_cmd_t   push_cmd;
  logic        pop;
  kpws_cmd_t   head;
  kpws_qstat_t qstat;

  kpws_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .qstat     (qstat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  kpws_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  kpws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
